[rtl/core/lttl_pkg.sv]
// Shared constants and codes for the keyed LRU/TTL cache.
package lttl_pkg;

  // Parameter defaults
  localparam int unsigned ENTRIES_DEF      = 256;
  localparam int unsigned PAYLOAD_BITS_DEF = 32;

  // Register reset values and fixed words
  localparam logic [31:0] TTL_RESET  = 32'd3600;
  localparam logic        ENABLE_RESET = 1'b1;
  localparam logic [31:0] MISS_SCORE = 32'hBF80_0000;

  // Register index, taken from paddr[2]
  localparam logic REG_ENABLE = 1'b0;
  localparam logic REG_TTL    = 1'b1;

  // Operation codes
  localparam logic FUNC_LOOKUP = 1'b0;
  localparam logic FUNC_STORE  = 1'b1;

endpackage

[rtl/core/lttl_if.sv]
// Request and response channel interfaces for the keyed cache.
interface lttl_req_if;
  logic        valid;
  logic        ready;
  logic        func;
  logic [63:0] key;
  logic [31:0] now;
  logic [31:0] score_in;
  logic [31:0] payload_in;
  modport source (output valid, func, key, now, score_in, payload_in, input ready);
  modport sink   (input valid, func, key, now, score_in, payload_in, output ready);
endinterface

interface lttl_rsp_if;
  logic        valid;
  logic        ready;
  logic        hit;
  logic [31:0] score_out;
  logic [31:0] payload_out;
  modport source (output valid, hit, score_out, payload_out, input ready);
  modport sink   (input valid, hit, score_out, payload_out, output ready);
endinterface

[rtl/core/lttl_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module lttl_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[rtl/core/lru_ttl_keyed_cache.sv]
// Keyed cache top level: one entry RAM, sequential scan over filled slots.
// Operation: an active item reads fill slots, one per cycle, and the result is registered;
// a new item is taken only when the last one is done. A hit ends the scan early, and a
// lookup waits while an earlier result is still stalled on the output.
// A disabled or zero-key lookup skips the scan and gives a miss; such a store is dropped.
// Reset (synchronous, active low) clears fill count, stamp counter and control; slots at or above the fill count read as empty, so no clearing pass is needed.
module lru_ttl_keyed_cache #(
  parameter int unsigned ENTRIES      = lttl_pkg::ENTRIES_DEF,
  parameter int unsigned PAYLOAD_BITS = lttl_pkg::PAYLOAD_BITS_DEF
) (
  input  logic         clk,
  input  logic         rst_n,
  lttl_req_if.sink     in_ch,
  lttl_rsp_if.source   out_ch,
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [2:0]   paddr,
  input  logic [31:0]  pwdata,
  output logic [31:0]  prdata,
  output logic         pready
);

  localparam int unsigned AW = $clog2(ENTRIES);
  localparam int unsigned PB = PAYLOAD_BITS;
  // Entry layout: key | time | stamp | score | payload
  localparam int unsigned EW = 64 + 32 + 64 + 32 + PB;
  localparam int unsigned O_SCORE = PB;
  localparam int unsigned O_STAMP = PB + 32;
  localparam int unsigned O_TIME  = PB + 96;
  localparam int unsigned O_KEY   = PB + 128;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;
  localparam logic [1:0] S_ACT  = 2'd2;

  logic [1:0]  state_r;
  logic        enable_r;
  logic [31:0] ttl_r;

  // Latched request
  logic        func_r;
  logic [63:0] key_r;
  logic [31:0] now_r;
  logic [31:0] score_in_r;
  logic [PB-1:0] payload_in_r;

  // Scan state
  logic [AW:0]   fill_r;
  logic [AW:0]   iss_r;
  logic          chk_r;
  logic [AW-1:0] chk_idx_r;
  logic          found_r;
  logic [AW-1:0] hit_idx_r;
  logic [EW-1:0] hit_ent_r;
  logic [63:0]   min_stamp_r;
  logic [AW-1:0] victim_r;
  logic [63:0]   stamp_cnt_r;

  // Response register
  logic        out_valid_r;
  logic        hit_r;
  logic [31:0] score_r;
  logic [31:0] payload_r;

  // RAM ports
  logic          we;
  logic [AW-1:0] waddr;
  logic [EW-1:0] wdata;
  logic [EW-1:0] rdata;

  lttl_ram #(.WIDTH(EW), .DEPTH(ENTRIES)) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (iss_r[AW-1:0]),
    .rdata (rdata)
  );

  // Configuration port
  logic cfg_wr;
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;
  always_comb begin
    prdata = 32'd0;
    case (paddr[2])
      lttl_pkg::REG_ENABLE: prdata = {31'd0, enable_r};
      lttl_pkg::REG_TTL:    prdata = ttl_r;
      default:              prdata = 32'd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enable_r <= lttl_pkg::ENABLE_RESET;
      ttl_r    <= lttl_pkg::TTL_RESET;
    end else if (cfg_wr) begin
      case (paddr[2])
        lttl_pkg::REG_ENABLE: enable_r <= pwdata[0];
        lttl_pkg::REG_TTL:    ttl_r    <= pwdata;
        default: ;
      endcase
    end
  end

  // Handshakes
  logic in_xfer, out_xfer, active_in, act_go, is_lookup;
  assign in_ch.ready = (state_r == S_IDLE);
  assign in_xfer     = in_ch.valid && in_ch.ready;
  assign out_xfer    = out_ch.valid && out_ch.ready;
  assign active_in   = enable_r && (in_ch.key != 64'd0);
  assign is_lookup   = (func_r == lttl_pkg::FUNC_LOOKUP);
  assign act_go      = (state_r == S_ACT) && (!is_lookup || !out_valid_r || out_ch.ready);

  // Evaluation of the slot whose read data is arriving
  logic [63:0] e_key, e_stamp;
  logic [31:0] e_time;
  logic signed [32:0] age;
  logic e_hit, scan_more, scan_done;
  assign e_key   = rdata[O_KEY +: 64];
  assign e_time  = rdata[O_TIME +: 32];
  assign e_stamp = rdata[O_STAMP +: 64];
  assign age     = $signed({1'b0, now_r}) - $signed({1'b0, e_time});
  assign e_hit   = chk_r && (e_key == key_r) && (e_time != 32'd0) &&
                   (age < $signed({1'b0, ttl_r}));
  assign scan_more = (iss_r < fill_r);
  assign scan_done = e_hit || (!chk_r && !scan_more);

  // Write-back target and data
  logic [63:0]   stamp_next;
  logic [AW-1:0] store_idx;
  logic          fill_grow;
  assign stamp_next = stamp_cnt_r + 64'd1;
  assign fill_grow  = !found_r && (fill_r < (AW+1)'(ENTRIES));
  assign store_idx  = found_r ? hit_idx_r : (fill_grow ? fill_r[AW-1:0] : victim_r);

  always_comb begin
    we    = 1'b0;
    waddr = store_idx;
    wdata = hit_ent_r;
    if (act_go && found_r && is_lookup) begin
      we    = 1'b1;
      wdata = hit_ent_r;
      wdata[O_STAMP +: 64] = stamp_next;
    end else if (act_go && !is_lookup) begin
      we    = 1'b1;
      wdata = {key_r, now_r, stamp_next, score_in_r, payload_in_r};
    end
  end

  // Response payload view of stored payload
  logic [63:0] pout64;
  assign pout64 = 64'(hit_ent_r[PB-1:0]);

  // Control sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      fill_r      <= '0;
      iss_r       <= '0;
      chk_r       <= 1'b0;
      found_r     <= 1'b0;
      stamp_cnt_r <= '0;
    end else begin
      case (state_r)
        S_IDLE: begin
          if (in_xfer) begin
            iss_r   <= '0;
            chk_r   <= 1'b0;
            found_r <= 1'b0;
            if (active_in) begin
              state_r <= S_SCAN;
            end else if (in_ch.func == lttl_pkg::FUNC_LOOKUP) begin
              state_r <= S_ACT;
            end
          end
        end
        S_SCAN: begin
          if (e_hit) begin
            found_r <= 1'b1;
          end
          if (scan_done) begin
            chk_r   <= 1'b0;
            state_r <= S_ACT;
          end else begin
            chk_r <= scan_more;
            if (scan_more) begin
              iss_r <= iss_r + 1'b1;
            end
          end
        end
        S_ACT: begin
          if (act_go) begin
            state_r <= S_IDLE;
            if (is_lookup) begin
              if (found_r) begin
                stamp_cnt_r <= stamp_next;
              end
            end else begin
              stamp_cnt_r <= stamp_next;
              if (fill_grow) begin
                fill_r <= fill_r + 1'b1;
              end
            end
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  // Response valid: set when a lookup finishes, cleared by its transfer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (act_go && is_lookup) begin
      out_valid_r <= 1'b1;
    end else if (out_xfer) begin
      out_valid_r <= 1'b0;
    end
  end

  function automatic logic [PB-1:0] pin_trunc(input logic [31:0] p);
    logic [63:0] w;
    w = {32'd0, p};
    return w[PB-1:0];
  endfunction

  // Datapath registers
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      func_r       <= in_ch.func;
      key_r        <= in_ch.key;
      now_r        <= in_ch.now;
      score_in_r   <= in_ch.score_in;
      payload_in_r <= pin_trunc(in_ch.payload_in);
      min_stamp_r  <= '1;
      victim_r     <= '0;
    end
    if (state_r == S_SCAN) begin
      chk_idx_r <= iss_r[AW-1:0];
      if (e_hit) begin
        hit_idx_r <= chk_idx_r;
        hit_ent_r <= rdata;
      end else if (chk_r && (e_stamp < min_stamp_r)) begin
        min_stamp_r <= e_stamp;
        victim_r    <= chk_idx_r;
      end
    end
    if (act_go && is_lookup) begin
      hit_r     <= found_r;
      score_r   <= found_r ? hit_ent_r[O_SCORE +: 32] : lttl_pkg::MISS_SCORE;
      payload_r <= found_r ? pout64[31:0] : 32'd0;
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.hit         = hit_r;
  assign out_ch.score_out   = score_r;
  assign out_ch.payload_out = payload_r;

  // Checks
  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= (AW+1)'(ENTRIES)) else $error("fill count above depth");
  a_fill_step: assert property (@(posedge clk) disable iff (!rst_n)
    (fill_r != $past(fill_r)) |-> (fill_r == $past(fill_r) + 1'b1 && $past(act_go)))
    else $error("fill count moved outside a store");
  a_stamp_act: assert property (@(posedge clk) disable iff (!rst_n)
    (stamp_cnt_r != $past(stamp_cnt_r)) |-> $past(act_go))
    else $error("stamp counter moved outside write-back");

endmodule

[sim/tb_lru_ttl_keyed_cache.sv]
// Testbench for the keyed LRU/TTL cache: directed table, random traffic, scoreboard.
module tb_lru_ttl_keyed_cache;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NSLOTS       = 256;
  localparam int DRAIN_CYCLES = 300;   // longest scan plus margin
  localparam int HOLD_CYCLES  = 800;   // long receiver hold-off
  localparam int IDLE_LIMIT   = 4000;
  localparam int MAX_REPORTS  = 10;

  typedef enum logic { ROW_ITEM, ROW_CFG } row_kind_t;

  typedef struct {
    row_kind_t   kind;
    logic        func;
    logic [63:0] key;
    logic [31:0] now;
    logic [31:0] score;
    logic [31:0] payload;
    bit          typed;
    logic        hit;
    logic [31:0] score_exp;
    logic [31:0] payload_exp;
    logic        reg_sel;
    logic [31:0] value;
  } stim_row_t;

  typedef struct {
    logic        hit;
    logic [31:0] score;
    logic [31:0] payload;
  } lookup_rsp_t;

  logic clk;
  logic rst_n;
  logic psel, penable, pwrite, pready;
  logic [2:0]  paddr;
  logic [31:0] pwdata, prdata;

  lttl_req_if req_ch ();
  lttl_rsp_if rsp_ch ();

  lru_ttl_keyed_cache dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (req_ch.sink),
    .out_ch (rsp_ch.source),
    .psel   (psel),
    .penable(penable),
    .pwrite (pwrite),
    .paddr  (paddr),
    .pwdata (pwdata),
    .prdata (prdata),
    .pready (pready)
  );

  // Shadow state of the cache
  logic [63:0] sh_key     [NSLOTS];
  logic [31:0] sh_score   [NSLOTS];
  logic [31:0] sh_payload [NSLOTS];
  logic [31:0] sh_time    [NSLOTS];
  logic [63:0] sh_stamp   [NSLOTS];
  logic [63:0] sh_stamp_ctr;
  logic        sh_enable;
  logic [31:0] sh_ttl;

  lookup_rsp_t pending_rsp[$];
  int mismatches, n_lookups, n_hits, n_stores, n_checked, idle_cycles;
  bit hold_request;
  logic [63:0] key_pool[320];

  // Clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic bit slot_fresh(int i, logic [31:0] now);
    longint age;
    if (sh_time[i] == 32'd0) return 1'b0;
    age = longint'({32'd0, now}) - longint'({32'd0, sh_time[i]});
    return age < longint'({32'd0, sh_ttl});
  endfunction

  // Apply one accepted request to the shadow cache; returns 1 if a response follows
  function automatic bit cache_apply(input logic func, input logic [63:0] key,
                                     input logic [31:0] now, input logic [31:0] score,
                                     input logic [31:0] payload, output lookup_rsp_t rsp);
    int          found, empty, victim;
    logic [63:0] min_stamp;
    bit          active;
    active    = sh_enable && (key != 64'd0);
    rsp.hit   = 1'b0;
    rsp.score = lttl_pkg::MISS_SCORE;
    rsp.payload = 32'd0;
    found     = -1;
    empty     = -1;
    victim    = 0;
    min_stamp = '1;
    if (active) begin
      for (int i = 0; i < NSLOTS; i++) begin
        if (sh_key[i] == 64'd0) begin
          if (empty < 0) empty = i;
        end else if (sh_key[i] == key && slot_fresh(i, now)) begin
          found = i;
          break;
        end else if (sh_stamp[i] < min_stamp) begin
          min_stamp = sh_stamp[i];
          victim = i;
        end
      end
    end
    if (func == lttl_pkg::FUNC_LOOKUP) begin
      if (found >= 0) begin
        sh_stamp_ctr++;
        sh_stamp[found] = sh_stamp_ctr;
        rsp.hit = 1'b1;
        rsp.score = sh_score[found];
        rsp.payload = sh_payload[found];
      end
      return 1'b1;
    end
    if (!active) return 1'b0;
    if (found < 0) found = (empty >= 0) ? empty : victim;
    sh_key[found] = key;
    sh_score[found] = score;
    sh_payload[found] = payload;
    sh_time[found] = now;
    sh_stamp_ctr++;
    sh_stamp[found] = sh_stamp_ctr;
    return 1'b0;
  endfunction

  // Drive one request; predict at the transfer edge
  task automatic send_request(input logic func, input logic [63:0] key, input logic [31:0] now,
                              input logic [31:0] score, input logic [31:0] payload,
                              input bit typed, input lookup_rsp_t typed_rsp);
    int          gap;
    lookup_rsp_t rsp;
    gap = $urandom_range(0, 5);
    if (gap > 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_ch.valid      <= 1'b1;
    req_ch.func       <= func;
    req_ch.key        <= key;
    req_ch.now        <= now;
    req_ch.score_in   <= score;
    req_ch.payload_in <= payload;
    do @(posedge clk); while (!(req_ch.valid && req_ch.ready));
    if (cache_apply(func, key, now, score, payload, rsp)) begin
      n_lookups++;
      if (rsp.hit) n_hits++;
      pending_rsp.push_back(typed ? typed_rsp : rsp);
    end else if (func == lttl_pkg::FUNC_STORE) begin
      n_stores++;
    end
  endtask

  // Stop offering, let every response and any store scan finish
  task automatic wait_idle();
    req_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending_rsp.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic reg_sel, input logic [31:0] value);
    wait_idle();
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {reg_sel, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    if (reg_sel == lttl_pkg::REG_ENABLE) sh_enable = value[0];
    else sh_ttl = value;
  endtask

  function automatic stim_row_t item_row(logic func, logic [63:0] key, logic [31:0] now,
                                         logic [31:0] score, logic [31:0] payload,
                                         bit typed = 0, logic hit = 0,
                                         logic [31:0] sc = lttl_pkg::MISS_SCORE,
                                         logic [31:0] pl = 0);
    stim_row_t r;
    r = '{kind: ROW_ITEM, func: func, key: key, now: now, score: score, payload: payload,
          typed: typed, hit: hit, score_exp: sc, payload_exp: pl,
          reg_sel: lttl_pkg::REG_ENABLE, value: 32'd0};
    return r;
  endfunction

  function automatic stim_row_t cfg_row(logic reg_sel, logic [31:0] value);
    stim_row_t r;
    r = item_row(lttl_pkg::FUNC_LOOKUP, 64'd0, 32'd0, 32'd0, 32'd0);
    r.kind = ROW_CFG;
    r.reg_sel = reg_sel;
    r.value = value;
    return r;
  endfunction

  // Response side: random stalls and one long hold-off
  initial begin
    int stall;
    lookup_rsp_t want;
    stall = 0;
    rsp_ch.ready <= 1'b0;
    @(posedge clk iff rst_n);
    rsp_ch.ready <= 1'b1;
    forever begin
      @(posedge clk);
      if (rsp_ch.valid && rsp_ch.ready) begin
        if (pending_rsp.size() == 0) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display("unexpected response: hit=%0b score=%h payload=%h",
                     rsp_ch.hit, rsp_ch.score_out, rsp_ch.payload_out);
        end else begin
          want = pending_rsp.pop_front();
          n_checked++;
          if (rsp_ch.hit !== want.hit || rsp_ch.score_out !== want.score ||
              rsp_ch.payload_out !== want.payload) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
              $display("response %0d: expected hit=%0b score=%h payload=%h, got %0b %h %h",
                       n_checked, want.hit, want.score, want.payload,
                       rsp_ch.hit, rsp_ch.score_out, rsp_ch.payload_out);
          end
        end
        stall = $urandom_range(0, 5);
        if (hold_request) begin
          stall = HOLD_CYCLES;
          hold_request = 0;
        end
        if (stall > 0) rsp_ch.ready <= 1'b0;
      end else if (!rsp_ch.ready) begin
        if (stall > 0) stall--;
        if (stall == 0) rsp_ch.ready <= 1'b1;
      end
    end
  end

  // Watchdog: cycles without any transfer
  initial begin
    idle_cycles = 0;
    forever begin
      @(posedge clk);
      if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) || psel)
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("timeout with %0d responses outstanding", pending_rsp.size());
        $display("tb_lru_ttl_keyed_cache: errors");
        $finish;
      end
    end
  end

  // Stimulus
  initial begin
    stim_row_t   rows[$];
    lookup_rsp_t typed_rsp;
    logic [63:0] key_a, key_b, key_c, key_d, key;
    logic [31:0] base_t, now;
    logic [31:0] phase_ttl[6];
    logic        phase_en[6];
    int          sel;

    rst_n   <= 1'b0;
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= '0;
    pwdata  <= '0;
    req_ch.valid      <= 1'b0;
    req_ch.func       <= lttl_pkg::FUNC_LOOKUP;
    req_ch.key        <= '0;
    req_ch.now        <= '0;
    req_ch.score_in   <= '0;
    req_ch.payload_in <= '0;
    mismatches = 0; n_lookups = 0; n_hits = 0; n_stores = 0; n_checked = 0;
    hold_request = 0;
    for (int i = 0; i < NSLOTS; i++) begin
      sh_key[i] = '0; sh_score[i] = '0; sh_payload[i] = '0; sh_time[i] = '0; sh_stamp[i] = '0;
    end
    sh_stamp_ctr = '0;
    sh_enable = lttl_pkg::ENABLE_RESET;
    sh_ttl = lttl_pkg::TTL_RESET;
    foreach (key_pool[i]) begin
      do key_pool[i] = {$urandom, $urandom}; while (key_pool[i] == 64'd0);
    end
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part
    key_a = 64'h0123_4567_89AB_CDEF;
    key_b = 64'h8000_0000_0000_0001;
    key_c = 64'h7FFF_0000_FFFF_0000;
    key_d = 64'h0000_0000_0000_0002;
    rows.push_back(item_row(lttl_pkg::FUNC_LOOKUP, key_a, 100, 0, 0, 1));   // empty cache
    rows.push_back(item_row(lttl_pkg::FUNC_LOOKUP, 64'd0, 100, 0, 0, 1));   // no key
    rows.push_back(item_row(lttl_pkg::FUNC_STORE, 64'd0, 100, 32'h1, 32'h1)); // ignored store
    rows.push_back(item_row(lttl_pkg::FUNC_STORE, key_a, 100, 32'h3F80_0000, 32'h11));
    rows.push_back(item_row(lttl_pkg::FUNC_LOOKUP, key_a, 200, 0, 0, 1, 1,
                            32'h3F80_0000, 32'h11));
    rows.push_back(item_row(lttl_pkg::FUNC_LOOKUP, key_a, 3700, 0, 0, 1));  // age == ttl
    rows.push_back(item_row(lttl_pkg::FUNC_LOOKUP, key_a, 50, 0, 0));       // stored in future
    rows.push_back(item_row(lttl_pkg::FUNC_STORE, key_b, 0, 32'h5, 32'h6)); // time zero
    rows.push_back(item_row(lttl_pkg::FUNC_LOOKUP, key_b, 0, 0, 0, 1));
    rows.push_back(item_row(lttl_pkg::FUNC_STORE, '1, '1, '1, '1));
    rows.push_back(item_row(lttl_pkg::FUNC_LOOKUP, '1, '1, 0, 0, 1, 1, '1, '1));
    rows.push_back(item_row(lttl_pkg::FUNC_STORE, key_a, 300, 32'h0, 32'h0)); // overwrite
    rows.push_back(item_row(lttl_pkg::FUNC_LOOKUP, key_a, 300, 0, 0));
    rows.push_back(cfg_row(lttl_pkg::REG_TTL, 32'd0));
    rows.push_back(item_row(lttl_pkg::FUNC_STORE, key_d, 1000, 32'hA5A5_5A5A, 32'h77));
    rows.push_back(item_row(lttl_pkg::FUNC_LOOKUP, key_d, 1000, 0, 0, 1));  // nothing fresh
    rows.push_back(item_row(lttl_pkg::FUNC_LOOKUP, key_d, 999, 0, 0));      // negative age
    rows.push_back(cfg_row(lttl_pkg::REG_TTL, 32'hFFFF_FFFF));
    rows.push_back(item_row(lttl_pkg::FUNC_LOOKUP, key_a, '1, 0, 0));
    rows.push_back(cfg_row(lttl_pkg::REG_ENABLE, 32'd0));
    rows.push_back(item_row(lttl_pkg::FUNC_LOOKUP, key_a, 300, 0, 0, 1));   // disabled
    rows.push_back(item_row(lttl_pkg::FUNC_STORE, key_c, 300, 32'h9, 32'h9));
    rows.push_back(cfg_row(lttl_pkg::REG_ENABLE, 32'd1));
    rows.push_back(item_row(lttl_pkg::FUNC_LOOKUP, key_c, 300, 0, 0, 1));
    rows.push_back(cfg_row(lttl_pkg::REG_TTL, lttl_pkg::TTL_RESET));

    foreach (rows[i]) begin
      if (rows[i].kind == ROW_CFG) begin
        write_reg(rows[i].reg_sel, rows[i].value);
      end else begin
        typed_rsp = '{hit: rows[i].hit, score: rows[i].score_exp, payload: rows[i].payload_exp};
        send_request(rows[i].func, rows[i].key, rows[i].now, rows[i].score, rows[i].payload,
                     rows[i].typed, typed_rsp);
      end
    end

    // Random part: phases with different settings
    phase_ttl = '{lttl_pkg::TTL_RESET, 32'd50, 32'd0, 32'hFFFF_FFFF, $urandom, 32'd200};
    phase_en  = '{1'b1, 1'b1, 1'b0, 1'b1, 1'b1, 1'b1};
    base_t = 32'd5000;
    typed_rsp = '{hit: 1'b0, score: lttl_pkg::MISS_SCORE, payload: 32'd0};
    for (int p = 0; p < 6; p++) begin
      write_reg(lttl_pkg::REG_TTL, phase_ttl[p]);
      write_reg(lttl_pkg::REG_ENABLE, {31'd0, phase_en[p]});
      for (int n = 0; n < 250; n++) begin
        sel = $urandom_range(0, 99);
        if (sel < 90) key = key_pool[$urandom_range(0, 319)];
        else if (sel < 95) key = 64'd0;
        else key = {$urandom, $urandom};
        base_t += $urandom_range(0, 30);
        now = ($urandom_range(0, 9) == 0) ? $urandom : base_t;
        if (p == 1 && n == 120) hold_request = 1;
        send_request(1'($urandom_range(0, 1)), key, now, $urandom, $urandom, 0, typed_rsp);
      end
    end

    wait_idle();
    $display("covered %0d lookups (%0d hits) and %0d stores, ttl at 0, max and reset values,",
             n_lookups, n_hits, n_stores);
    $display("cache enabled and disabled, eviction when full, one long output hold-off");
    if (mismatches == 0 && pending_rsp.size() == 0) begin
      $display("tb_lru_ttl_keyed_cache: clean");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("tb_lru_ttl_keyed_cache: errors");
    end
    $finish;
  end

endmodule

[filelist.f]
rtl/core/lttl_pkg.sv
rtl/core/lttl_if.sv
rtl/core/lttl_ram.sv
rtl/core/lru_ttl_keyed_cache.sv
sim/tb_lru_ttl_keyed_cache.sv
